FILE: rtl/core/periodic_task_dispatcher_assert.svh
// assertion macros for the periodic task dispatcher
`ifndef PERIODIC_TASK_DISPATCHER_ASSERT_SVH
`define PERIODIC_TASK_DISPATCHER_ASSERT_SVH
`ifndef SYNTHESIS
`define PTD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define PTD_ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("assertion failed");
`else
`define PTD_ASSERT(label, clk, rst_n, prop)
`define PTD_ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

FILE: rtl/core/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// shared codes and types of the periodic task dispatcher
// ----------------------------------------------------------------------------
package ptd_pkg;
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_POLL   = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  localparam logic [2:0] KIND_ADDED    = 3'd0;
  localparam logic [2:0] KIND_FULL     = 3'd1;
  localparam logic [2:0] KIND_RUN      = 3'd2;
  localparam logic [2:0] KIND_DONE     = 3'd3;
  localparam logic [2:0] KIND_REPORTED = 3'd4;
  localparam logic [2:0] KIND_IGNORED  = 3'd5;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;
endpackage

FILE: rtl/core/ptd_divider.sv
// ----------------------------------------------------------------------------
// ptd_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "periodic_task_dispatcher_assert.svh"
module ptd_divider
  import ptd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output div_ctrl_t   ctrl_o,
  output logic [31:0] quot_o
);
  logic [31:0] rem_q, rem_d, quot_q, quot_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[31]} - {1'b0, den_q};
    if (start_i) begin
      rem_d  = '0;
      quot_d = num_i;
      den_d  = den_i;
      cnt_d  = 6'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quot_q[31]};
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

  assign ctrl_o.start = start_i;
  assign ctrl_o.busy  = busy_q;
  assign ctrl_o.done  = done_q;
  assign quot_o       = quot_q;

  `PTD_ASSERT(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q))
  `PTD_ASSERT_NEVER(a_done_and_busy, clk_i, rst_ni, done_q && busy_q)
  `PTD_ASSERT(a_start_busy, clk_i, rst_ni, start_i |=> busy_q)
endmodule

FILE: rtl/core/periodic_task_dispatcher.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// task table with add, poll and duration report, one item at a time
// ----------------------------------------------------------------------------
// add: result loaded in the ADD state; poll: remove pass over the tasks held,
// then visit pass over those left, one slot per cycle unless the output stalls;
// report: sum updated, then the bit-serial divider runs before the result
// throughput: one item at a time, next item accepted once the last result
// of the current one is taken
// reset: slot valid bits and task count cleared, task fields left unset
`include "periodic_task_dispatcher_assert.svh"
module periodic_task_dispatcher
  import ptd_pkg::*;
#(
  parameter int NUM_TASKS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] now_ms_i,
  input  logic [30:0] delay_ms_i,
  input  logic [14:0] max_runs_i,
  input  logic [2:0]  slot_i,
  input  logic [31:0] duration_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [2:0]  task_slot_o,
  output logic [31:0] run_count_o,
  output logic [31:0] average_ms_o,
  output logic [3:0]  active_tasks_o,
  output logic        last_o
);
  localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CW = $clog2(NUM_TASKS + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ADD, ST_PURGE, ST_VISIT, ST_DIV, ST_OUT
  } state_e;

  state_e              state_q;
  logic [NUM_TASKS-1:0] valid_q;
  logic [IW-1:0]       order_q [NUM_TASKS];
  logic [CW-1:0]       count_q;
  logic [30:0]         period_q [NUM_TASKS];
  logic [14:0]         limit_q [NUM_TASKS];
  logic [31:0]         start_q [NUM_TASKS];
  logic [31:0]         runs_q [NUM_TASKS];
  logic [31:0]         total_q [NUM_TASKS];
  logic [31:0]         avg_q [NUM_TASKS];

  logic [1:0]  op_q;
  logic [31:0] now_q, dur_q;
  logic [30:0] delay_q;
  logic [14:0] maxr_q;
  logic [2:0]  rslot_q;
  logic [CW-1:0] idx_q, wr_q;
  logic        cont_q;

  logic        ovalid_q, olast_q;
  logic [2:0]  okind_q, oslot_q;
  logic [31:0] oruns_q, oavg_q;

  // free slot search
  logic [IW-1:0] free_s;
  logic          free_f;
  always_comb begin
    free_s = '0;
    free_f = 1'b0;
    for (int i = NUM_TASKS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_s = IW'(i);
        free_f = 1'b1;
      end
    end
  end

  logic [IW-1:0] cur_s;
  logic [IW-1:0] rs_idx;
  logic          rs_ok;
  logic [31:0]   elapsed, sum33_lo, new_runs;
  logic [32:0]   sum33;
  logic          is_due, is_dead;
  assign cur_s    = order_q[idx_q[IW-1:0]];
  assign elapsed  = now_q - start_q[cur_s];
  assign is_due   = (period_q[cur_s] == 31'd0) || (elapsed >= {1'b0, period_q[cur_s]});
  assign is_dead  = (limit_q[cur_s] != 15'd0) && (runs_q[cur_s] >= {17'd0, limit_q[cur_s]});
  assign new_runs = (runs_q[cur_s] == MAX32) ? MAX32 : runs_q[cur_s] + 32'd1;
  assign rs_idx   = rslot_q[IW-1:0];
  assign rs_ok    = ({29'd0, rslot_q} < 32'(NUM_TASKS)) && valid_q[rs_idx]
                    && (runs_q[rs_idx] != 32'd0);
  assign sum33    = {1'b0, total_q[rs_idx]} + {1'b0, dur_q};
  assign sum33_lo = sum33[32] ? MAX32 : sum33[31:0];

  div_ctrl_t   dctl;
  logic [31:0] quot;
  logic        div_start;
  assign div_start = (state_q == ST_IDLE) && in_valid_i && !in_stall_o && 1'b0;

  logic        dgo_q;
  ptd_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dgo_q),
    .num_i  (total_q[rs_idx]),
    .den_i  (runs_q[rs_idx]),
    .ctrl_o (dctl),
    .quot_o (quot)
  );

  logic out_free;
  assign out_free   = !ovalid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || ovalid_q;

  // a new result item is loaded this cycle
  logic out_set;
  assign out_set = (state_q == ST_ADD)
                   || (state_q == ST_VISIT && out_free && (idx_q >= count_q || is_due))
                   || (state_q == ST_DIV && ((!cont_q && !rs_ok) || (cont_q && dctl.done)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= '0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
      dgo_q    <= 1'b0;
      idx_q    <= '0;
      wr_q     <= '0;
      cont_q   <= 1'b0;
    end else begin
      if (dgo_q) dgo_q <= 1'b0;
      if (ovalid_q && !out_stall_i && !out_set) ovalid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && !in_stall_o) begin
            case (opcode_i)
              OP_ADD:    state_q <= ST_ADD;
              OP_POLL: begin
                state_q <= ST_PURGE;
                idx_q   <= '0;
                wr_q    <= '0;
              end
              OP_REPORT: state_q <= ST_DIV;
              default:   state_q <= ST_IDLE;
            endcase
            cont_q <= 1'b0;
          end
        end
        ST_ADD: begin
          ovalid_q <= 1'b1;
          olast_q  <= 1'b1;
          oruns_q  <= '0;
          oavg_q   <= '0;
          if (!free_f || count_q >= CW'(NUM_TASKS)) begin
            okind_q <= KIND_FULL;
            oslot_q <= '0;
          end else begin
            okind_q <= KIND_ADDED;
            oslot_q <= 3'(free_s);
            valid_q[free_s] <= 1'b1;
            period_q[free_s] <= delay_q;
            limit_q[free_s]  <= maxr_q;
            start_q[free_s]  <= now_q;
            runs_q[free_s]   <= '0;
            total_q[free_s]  <= '0;
            avg_q[free_s]    <= '0;
            for (int i = NUM_TASKS - 1; i > 0; i--) order_q[i] <= order_q[i-1];
            order_q[0] <= free_s;
            count_q <= count_q + CW'(1);
          end
          state_q <= ST_IDLE;
        end
        ST_PURGE: begin
          if (idx_q >= count_q) begin
            count_q <= wr_q;
            idx_q   <= '0;
            state_q <= ST_VISIT;
          end else begin
            if (is_dead) valid_q[cur_s] <= 1'b0;
            else begin
              order_q[wr_q[IW-1:0]] <= cur_s;
              wr_q <= wr_q + CW'(1);
            end
            idx_q <= idx_q + CW'(1);
          end
        end
        ST_VISIT: begin
          if (out_free) begin
            if (idx_q >= count_q) begin
              ovalid_q <= 1'b1;
              okind_q  <= KIND_DONE;
              oslot_q  <= '0;
              oruns_q  <= '0;
              oavg_q   <= '0;
              olast_q  <= 1'b1;
              state_q  <= ST_IDLE;
            end else begin
              if (is_due) begin
                if (period_q[cur_s] != 31'd0) start_q[cur_s] <= now_q;
                runs_q[cur_s] <= new_runs;
                ovalid_q <= 1'b1;
                okind_q  <= KIND_RUN;
                oslot_q  <= 3'(cur_s);
                oruns_q  <= new_runs;
                oavg_q   <= avg_q[cur_s];
                olast_q  <= 1'b0;
              end
              idx_q <= idx_q + CW'(1);
            end
          end
        end
        ST_DIV: begin
          if (!cont_q) begin
            cont_q <= 1'b1;
            if (!rs_ok) begin
              ovalid_q <= 1'b1;
              okind_q  <= KIND_IGNORED;
              oslot_q  <= rslot_q;
              oruns_q  <= '0;
              oavg_q   <= '0;
              olast_q  <= 1'b1;
              state_q  <= ST_IDLE;
            end else begin
              total_q[rs_idx] <= sum33_lo;
              dgo_q <= 1'b1;
            end
          end else if (dctl.done) begin
            avg_q[rs_idx] <= quot;
            ovalid_q <= 1'b1;
            okind_q  <= KIND_REPORTED;
            oslot_q  <= rslot_q;
            oruns_q  <= runs_q[rs_idx];
            oavg_q   <= quot;
            olast_q  <= 1'b1;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i && !in_stall_o) begin
      op_q    <= opcode_i;
      now_q   <= now_ms_i;
      delay_q <= delay_ms_i;
      maxr_q  <= max_runs_i;
      rslot_q <= slot_i;
      dur_q   <= duration_ms_i;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign kind_o         = okind_q;
  assign task_slot_o    = oslot_q;
  assign run_count_o    = oruns_q;
  assign average_ms_o   = oavg_q;
  assign active_tasks_o = 4'(count_q);
  assign last_o         = olast_q;

  `PTD_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CW'(NUM_TASKS))
  `PTD_ASSERT(a_count_valid, clk_i, rst_ni,
    (state_q == ST_IDLE) |-> ($countones(valid_q) == 32'(count_q)))
  `PTD_ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni,
    div_start || (dctl.busy && state_q != ST_DIV) || (op_q == 2'd3 && state_q == ST_ADD))
endmodule
